/* hdl/bfd_pkg.sv */
// buffer frame directory package: sizes, op codes and transfer structs
// shared by every module of the directory; depends on nothing
package bfd_pkg;

	localparam int FRAMES       = 64;
	localparam int PIN_BITS     = 8;
	localparam int FILE_ID_BITS = 16;
	localparam int IDX_W        = $clog2(FRAMES);

	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

	localparam logic [2:0] OP_ALLOC   = 3'd0;
	localparam logic [2:0] OP_LOOKUP  = 3'd1;
	localparam logic [2:0] OP_REG     = 3'd2;
	localparam logic [2:0] OP_UNREG   = 3'd3;
	localparam logic [2:0] OP_PIN     = 3'd4;
	localparam logic [2:0] OP_UNPIN   = 3'd5;
	localparam logic [2:0] OP_VICTIM  = 3'd6;
	localparam logic [2:0] OP_READ    = 3'd7;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  frame_index;
		logic [30:0] page_id;
		logic [15:0] file_id;
	} bfd_req_t;

	typedef struct packed {
		logic        found;
		logic [5:0]  result_frame;
		logic        entry_occupied;
		logic [30:0] entry_page;
		logic [15:0] entry_file;
		logic [7:0]  entry_pins;
	} bfd_rsp_t;

	typedef struct packed {
		logic                    vld;
		logic [2:0]              op;
		logic                    ok;
		logic [IDX_W-1:0]        idx;
		logic [30:0]             page;
		logic [FILE_ID_BITS-1:0] file;
		logic                    alloc_hit;
		logic [IDX_W-1:0]        alloc_idx;
	} bfd_upd_t;

	typedef struct packed {
		logic [FRAMES-1:0]       free;
		logic [FRAMES-1:0]       occ;
		logic [FRAMES-1:0]       match;
		logic [FRAMES-1:0]       unpinned;
		logic                    rd_occ;
		logic [30:0]             rd_page;
		logic [FILE_ID_BITS-1:0] rd_file;
		logic [PIN_BITS-1:0]     rd_pins;
	} bfd_tbl_t;

endpackage

/* hdl/bfd_prio.sv */
// lowest-index priority encoder over one flag per frame
// depends on bfd_pkg
module bfd_prio (
	input  logic [bfd_pkg::FRAMES-1:0] vec,
	output logic                       hit,
	output logic [bfd_pkg::IDX_W-1:0]  idx
);
	import bfd_pkg::*;

	logic [FRAMES-1:0] low;

	assign low = vec & (~vec + FRAMES'(1));
	assign hit = |vec;

	always_comb begin
		idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (low[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

endmodule

/* hdl/bfd_table.sv */
// frame table: free and occupied maps, tags and pin counts with per-frame compares
// depends on bfd_pkg
module bfd_table (
	input  logic              clk,
	input  logic              arst_n,
	input  bfd_pkg::bfd_upd_t upd,
	output bfd_pkg::bfd_tbl_t sts
);
	import bfd_pkg::*;

	logic [FRAMES-1:0]       free_q;
	logic [FRAMES-1:0]       occ_q;
	logic [30:0]             page_q [FRAMES];
	logic [FILE_ID_BITS-1:0] file_q [FRAMES];
	logic [PIN_BITS-1:0]     pins_q [FRAMES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			occ_q  <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				page_q[i] <= '0;
				file_q[i] <= '0;
				pins_q[i] <= '0;
			end
		end else if (upd.vld) begin
			case (upd.op)
				OP_ALLOC: begin
					if (upd.alloc_hit) begin
						free_q[upd.alloc_idx] <= 1'b0;
					end
				end
				OP_REG: begin
					if (upd.ok) begin
						page_q[upd.idx] <= upd.page;
						file_q[upd.idx] <= upd.file;
						pins_q[upd.idx] <= '0;
						occ_q[upd.idx]  <= 1'b1;
					end
				end
				OP_UNREG: begin
					if (upd.ok) begin
						page_q[upd.idx] <= '0;
						file_q[upd.idx] <= '0;
						pins_q[upd.idx] <= '0;
						occ_q[upd.idx]  <= 1'b0;
						free_q[upd.idx] <= 1'b1;
					end
				end
				OP_PIN: begin
					if (upd.ok && pins_q[upd.idx] != PIN_MAX) begin
						pins_q[upd.idx] <= pins_q[upd.idx] + PIN_BITS'(1);
					end
				end
				OP_UNPIN: begin
					if (upd.ok && pins_q[upd.idx] != '0) begin
						pins_q[upd.idx] <= pins_q[upd.idx] - PIN_BITS'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		sts      = '0;
		sts.free = free_q;
		sts.occ  = occ_q;
		for (int i = 0; i < FRAMES; i++) begin
			sts.match[i]    = (page_q[i] == upd.page) && (file_q[i] == upd.file);
			sts.unpinned[i] = (pins_q[i] == '0);
		end
		if (upd.ok) begin
			sts.rd_occ  = occ_q[upd.idx];
			sts.rd_page = page_q[upd.idx];
			sts.rd_file = file_q[upd.idx];
			sts.rd_pins = pins_q[upd.idx];
		end
	end

endmodule

/* hdl/buffer_frame_directory.sv */
// buffer frame directory top level: request register, frame table, encoder, result register
// depends on bfd_pkg, bfd_table and bfd_prio
// result strobe (done) and result: request register, then result register, with no stall between
// throughput: one request per cycle, busy never rises
// the result is shown for one cycle only; the receiver cannot stall
// reset: every frame free and unoccupied, tags and pin counts zero at once
module buffer_frame_directory (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bfd_pkg::bfd_req_t req,
	output logic              done,
	output bfd_pkg::bfd_rsp_t rsp
);
	import bfd_pkg::*;

	bfd_req_t         req_s1;
	logic             vld_s1;
	bfd_upd_t         upd;
	bfd_tbl_t         sts;
	logic [FRAMES-1:0] vec;
	logic             hit;
	logic [IDX_W-1:0] hit_idx;
	logic             ok;
	bfd_rsp_t         rsp_d;
	bfd_rsp_t         rsp_q;
	logic             done_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	assign ok = 32'(req_s1.frame_index) < 32'(FRAMES);

	assign upd.vld       = vld_s1;
	assign upd.op        = req_s1.op;
	assign upd.ok        = ok;
	assign upd.idx       = IDX_W'(req_s1.frame_index);
	assign upd.page      = req_s1.page_id;
	assign upd.file      = FILE_ID_BITS'(req_s1.file_id);
	assign upd.alloc_hit = hit;
	assign upd.alloc_idx = hit_idx;

	bfd_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.sts    (sts)
	);

	always_comb begin
		case (req_s1.op)
			OP_ALLOC:  vec = sts.free;
			OP_LOOKUP: vec = sts.occ & sts.match;
			OP_VICTIM: vec = sts.occ & sts.unpinned;
			default:   vec = '0;
		endcase
	end

	bfd_prio u_prio (
		.vec (vec),
		.hit (hit),
		.idx (hit_idx)
	);

	always_comb begin
		rsp_d = '0;
		case (req_s1.op)
			OP_ALLOC, OP_LOOKUP, OP_VICTIM: begin
				rsp_d.found        = hit;
				rsp_d.result_frame = 6'(hit_idx);
			end
			OP_READ: begin
				rsp_d.entry_occupied = sts.rd_occ;
				rsp_d.entry_page     = sts.rd_page;
				rsp_d.entry_file     = 16'(sts.rd_file);
				rsp_d.entry_pins     = 8'(sts.rd_pins);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* hdl/bfd_checker.sv */
// port-level checks for the buffer frame directory, bound to the top level
// depends on bfd_pkg and buffer_frame_directory
module bfd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input bfd_pkg::bfd_req_t req,
	input logic              done,
	input bfd_pkg::bfd_rsp_t rsp
);
	import bfd_pkg::*;

	// every accepted transfer is followed by its result strobe (done)
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("missing result after accepted request");

	a_no_frame_when_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.found) |-> (rsp.result_frame == 6'd0))
		else $error("result_frame nonzero without a hit");

	a_hit_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.found) |-> (!rsp.entry_occupied && rsp.entry_page == '0
			&& rsp.entry_file == '0 && rsp.entry_pins == '0))
		else $error("entry fields set on a search result");

	// tags are only ever written together with the occupied bit
	a_free_tags_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.entry_occupied) |-> (rsp.entry_page == '0 && rsp.entry_file == '0))
		else $error("unoccupied frame carries tags");

endmodule

bind buffer_frame_directory bfd_checker u_bfd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
